// ----- src/ptt_pkg.sv -----
// shared types and constants for the pending request timeout table
// no dependencies
package ptt_pkg;

  localparam int DEPTH   = 16;
  localparam int TAG_W   = 16;
  localparam int FIELD_W = 16;
  localparam int ID_W    = 32;
  localparam int TIME_W  = 48;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    KIND_INSERT  = 2'd0,
    KIND_REMOVE  = 2'd1,
    KIND_TIMEOUT = 2'd2,
    KIND_PURGE   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NONE = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef struct packed {
    logic              valid;
    logic              live;
    logic [ID_W-1:0]   id;
    logic [TAG_W-1:0]  conn;
    logic [TAG_W-1:0]  disp;
    logic [TIME_W-1:0] deadline;
  } entry_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic kill;
  } cell_ctl_t;

endpackage

// ----- src/ptt_cell.sv -----
// one table entry; takes its upper neighbor on shift, a new entry on load
// depends on ptt_pkg
module ptt_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  ptt_pkg::cell_ctl_t ctl,
  input  ptt_pkg::entry_t    new_entry,
  input  ptt_pkg::entry_t    nb_entry,
  output ptt_pkg::entry_t    entry
);
  import ptt_pkg::*;

  entry_t e_r, e_nxt;

  always_comb begin
    e_nxt = e_r;
    if (ctl.shift) begin
      e_nxt = nb_entry;
    end
    if (ctl.load) begin
      e_nxt = new_entry;
    end
    if (ctl.kill) begin
      e_nxt.live = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_r.valid <= 1'b0;
      e_r.live  <= 1'b0;
    end else begin
      e_r <= e_nxt;
    end
  end

  assign entry = e_r;

endmodule

// ----- src/pending_request_timeout_table.sv -----
// pending request table top: control sequencer over a row of ptt_cell entries
// depends on ptt_pkg and ptt_cell
//
// A transaction is taken when start is high and busy is low. Entries sit in a
// row of cells in insertion order, oldest in cell 0; deadline order is up to
// the user; the block does not sort. Remove and expiry close gaps by
// shifting the upper cells down one place. Insert and remove go through
// S_EXEC to a registered result. A timeout check drops expired dead entries
// in S_EXEC. A purge marks matches dead, then emits a result per match from
// S_PURGE, newest first. Each result is on the out_ ports for exactly one
// cycle, marked by out_valid, and must be taken then; out_last marks the last.
module pending_request_timeout_table (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        in_kind,
  input  logic [ptt_pkg::ID_W-1:0]          in_request_id,
  input  logic [ptt_pkg::FIELD_W-1:0]       in_connection_tag,
  input  logic [ptt_pkg::FIELD_W-1:0]       in_dispatch_tag,
  input  logic [ptt_pkg::TIME_W-1:0]        in_deadline,
  input  logic [ptt_pkg::TIME_W-1:0]        in_current_time,
  output logic                              out_valid,
  output logic [1:0]                        out_status,
  output logic [ptt_pkg::ID_W-1:0]          out_found_id,
  output logic [ptt_pkg::FIELD_W-1:0]       out_found_connection,
  output logic [ptt_pkg::FIELD_W-1:0]       out_found_dispatch,
  output logic [ptt_pkg::TIME_W-1:0]        out_next_deadline,
  output logic                              out_last
);
  import ptt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_EXEC  = 3'b010,
    S_PURGE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  kind_t             kind_r;
  logic [ID_W-1:0]   id_r;
  logic [TAG_W-1:0]  conn_r;
  logic [TAG_W-1:0]  disp_r;
  logic [TIME_W-1:0] dl_r;
  logic [TIME_W-1:0] now_r;

  logic [CNT_W-1:0]  used_r, used_nxt;
  logic [DEPTH-1:0]  pend_r, pend_nxt;

  logic              ov_r, ov_nxt;
  status_t           ost_r, ost_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [TAG_W-1:0]  oconn_r, oconn_nxt;
  logic [TAG_W-1:0]  odisp_r, odisp_nxt;
  logic [TIME_W-1:0] odl_r, odl_nxt;
  logic              olast_r, olast_nxt;

  entry_t    cells [DEPTH];
  cell_ctl_t ctl   [DEPTH];
  entry_t    new_entry;

  logic [DEPTH-1:0]  id_hit, conn_hit;
  logic              any_hit;
  logic [IDX_W-1:0]  hit_idx, top_idx;
  logic [TIME_W-1:0] head_dl;
  logic              do_load, do_shift, do_kill;
  logic [IDX_W-1:0]  shift_from;

  assign new_entry = '{valid: 1'b1, live: 1'b1, id: id_r, conn: conn_r,
                       disp: disp_r, deadline: dl_r};

  genvar g;
  generate
    for (g = 0; g < DEPTH; g++) begin : g_cell
      entry_t nb;
      if (g == DEPTH - 1) begin : g_end
        assign nb = '0;
      end else begin : g_mid
        assign nb = cells[g+1];
      end
      assign ctl[g].load  = do_load && (CNT_W'(g) == used_r);
      assign ctl[g].shift = do_shift && (IDX_W'(g) >= shift_from);
      assign ctl[g].kill  = do_kill && conn_hit[g];
      ptt_cell u_cell (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl[g]),
        .new_entry (new_entry),
        .nb_entry  (nb),
        .entry     (cells[g])
      );
    end
  endgenerate

  always_comb begin
    id_hit   = '0;
    conn_hit = '0;
    hit_idx  = '0;
    top_idx  = '0;
    for (int i = 0; i < DEPTH; i++) begin
      id_hit[i]   = cells[i].valid && (cells[i].id == id_r);
      conn_hit[i] = cells[i].valid && cells[i].live && (cells[i].conn == conn_r);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (id_hit[i]) begin
        hit_idx = IDX_W'(i);
      end
    end
    for (int i = 0; i < DEPTH; i++) begin
      if (pend_r[i]) begin
        top_idx = IDX_W'(i);
      end
    end
  end

  assign any_hit = |id_hit;
  assign head_dl = (used_r != '0) ? cells[0].deadline : '0;

  always_comb begin
    state_nxt  = state_r;
    used_nxt   = used_r;
    pend_nxt   = pend_r;
    do_load    = 1'b0;
    do_shift   = 1'b0;
    do_kill    = 1'b0;
    shift_from = '0;
    ov_nxt     = 1'b0;
    ost_nxt    = ST_OK;
    oid_nxt    = '0;
    oconn_nxt  = '0;
    odisp_nxt  = '0;
    odl_nxt    = head_dl;
    olast_nxt  = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        case (kind_r)
          KIND_INSERT: begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
            if (any_hit) begin
              ost_nxt = ST_DUP;
            end else if (used_r == CNT_W'(DEPTH)) begin
              ost_nxt = ST_FULL;
            end else begin
              do_load  = 1'b1;
              used_nxt = used_r + CNT_W'(1);
              odl_nxt  = (used_r == '0) ? dl_r : cells[0].deadline;
            end
          end
          KIND_REMOVE: begin
            ov_nxt    = 1'b1;
            state_nxt = S_IDLE;
            if (!any_hit) begin
              ost_nxt = ST_NONE;
            end else begin
              do_shift   = 1'b1;
              shift_from = hit_idx;
              used_nxt   = used_r - CNT_W'(1);
              oid_nxt    = id_r;
              oconn_nxt  = cells[hit_idx].conn;
              odisp_nxt  = cells[hit_idx].disp;
              if (used_r == CNT_W'(1)) begin
                odl_nxt = '0;
              end else if (hit_idx == '0) begin
                odl_nxt = cells[1].deadline;
              end else begin
                odl_nxt = cells[0].deadline;
              end
            end
          end
          KIND_TIMEOUT: begin
            if ((used_r != '0) && (cells[0].deadline <= now_r)) begin
              do_shift = 1'b1;
              used_nxt = used_r - CNT_W'(1);
              if (cells[0].live) begin
                ov_nxt    = 1'b1;
                state_nxt = S_IDLE;
                oid_nxt   = cells[0].id;
                oconn_nxt = cells[0].conn;
                odisp_nxt = cells[0].disp;
                odl_nxt   = (used_r == CNT_W'(1)) ? '0 : cells[1].deadline;
              end
            end else begin
              ov_nxt    = 1'b1;
              state_nxt = S_IDLE;
              ost_nxt   = ST_NONE;
            end
          end
          default: begin
            do_kill  = 1'b1;
            pend_nxt = conn_hit;
            if (conn_hit == '0) begin
              ov_nxt    = 1'b1;
              ost_nxt   = ST_NONE;
              state_nxt = S_IDLE;
            end else begin
              state_nxt = S_PURGE;
            end
          end
        endcase
      end
      S_PURGE: begin
        ov_nxt            = 1'b1;
        oid_nxt           = cells[top_idx].id;
        oconn_nxt         = conn_r;
        odisp_nxt         = cells[top_idx].disp;
        olast_nxt         = $onehot(pend_r);
        pend_nxt[top_idx] = 1'b0;
        if ($onehot(pend_r)) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      used_r  <= '0;
      pend_r  <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      used_r  <= used_nxt;
      pend_r  <= pend_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && start) begin
      kind_r <= kind_t'(in_kind);
      id_r   <= in_request_id;
      conn_r <= TAG_W'(in_connection_tag);
      disp_r <= TAG_W'(in_dispatch_tag);
      dl_r   <= in_deadline;
      now_r  <= in_current_time;
    end
    ost_r   <= ost_nxt;
    oid_r   <= oid_nxt;
    oconn_r <= oconn_nxt;
    odisp_r <= odisp_nxt;
    odl_r   <= odl_nxt;
    olast_r <= olast_nxt;
  end

  assign busy                 = (state_r != S_IDLE);
  assign out_valid            = ov_r;
  assign out_status           = ost_r;
  assign out_found_id         = oid_r;
  assign out_found_connection = FIELD_W'(oconn_r);
  assign out_found_dispatch   = FIELD_W'(odisp_r);
  assign out_next_deadline    = odl_r;
  assign out_last             = olast_r;

endmodule
